// ===== hw/rtl/sc1a_pkg.sv =====
// Package for the scan code set 1 to ASCII decoder.
// Holds the scan codes, ASCII constants, item kinds and the key map function.
// No dependencies.
`default_nettype none

package sc1a_pkg;

    // Key map storage: the shift flag and seven code bits address one entry.
    localparam int KM_DEPTH = 256;
    localparam int KM_AW    = 8;
    localparam int CH_W     = 7;

    localparam logic [7:0] SC_SHIFT_L_DN = 8'h2A;
    localparam logic [7:0] SC_SHIFT_R_DN = 8'h36;
    localparam logic [7:0] SC_SHIFT_L_UP = 8'hAA;
    localparam logic [7:0] SC_SHIFT_R_UP = 8'hB6;
    localparam logic [7:0] SC_CAPS_DN    = 8'h3A;
    localparam logic [7:0] SC_CTRL_DN    = 8'h1D;
    localparam logic [7:0] SC_CTRL_UP    = 8'h9D;
    localparam logic [7:0] SC_UP         = 8'h48;
    localparam logic [7:0] SC_DOWN       = 8'h50;

    localparam logic [CH_W-1:0] ASCII_NUL     = 7'h00;
    localparam logic [CH_W-1:0] ASCII_ESC     = 7'h1B;
    localparam logic [CH_W-1:0] ASCII_BRACKET = 7'h5B;
    localparam logic [CH_W-1:0] ASCII_UP_A    = 7'h41;
    localparam logic [CH_W-1:0] ASCII_UP_B    = 7'h42;
    localparam logic [CH_W-1:0] ASCII_UP_Z    = 7'h5A;
    localparam logic [CH_W-1:0] ASCII_LO_A    = 7'h61;
    localparam logic [CH_W-1:0] ASCII_LO_Z    = 7'h7A;
    localparam logic [CH_W-1:0] CASE_BIT      = 7'h20;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_UP,
        KIND_DOWN
    } kind_t;

    typedef enum logic {
        STEP_BRACKET,
        STEP_LETTER
    } run_step_t;

    // Returns the character for a make code, from the shifted or unshifted map.
    function automatic logic [CH_W-1:0] km_entry(input logic shifted,
                                                 input logic [6:0] code);
        logic [2*CH_W-1:0] pair;    // shifted character high, plain low
        begin
            case (code)
                7'h01: pair = {7'h1B, 7'h1B};
                7'h02: pair = {7'h21, 7'h31};
                7'h03: pair = {7'h40, 7'h32};
                7'h04: pair = {7'h23, 7'h33};
                7'h05: pair = {7'h24, 7'h34};
                7'h06: pair = {7'h25, 7'h35};
                7'h07: pair = {7'h5E, 7'h36};
                7'h08: pair = {7'h26, 7'h37};
                7'h09: pair = {7'h2A, 7'h38};
                7'h0A: pair = {7'h28, 7'h39};
                7'h0B: pair = {7'h29, 7'h30};
                7'h0C: pair = {7'h5F, 7'h2D};
                7'h0D: pair = {7'h2B, 7'h3D};
                7'h0E: pair = {7'h08, 7'h08};
                7'h0F: pair = {7'h09, 7'h09};
                7'h10: pair = {7'h51, 7'h71};
                7'h11: pair = {7'h57, 7'h77};
                7'h12: pair = {7'h45, 7'h65};
                7'h13: pair = {7'h52, 7'h72};
                7'h14: pair = {7'h54, 7'h74};
                7'h15: pair = {7'h59, 7'h79};
                7'h16: pair = {7'h55, 7'h75};
                7'h17: pair = {7'h49, 7'h69};
                7'h18: pair = {7'h4F, 7'h6F};
                7'h19: pair = {7'h50, 7'h70};
                7'h1A: pair = {7'h7B, 7'h5B};
                7'h1B: pair = {7'h7D, 7'h5D};
                7'h1C: pair = {7'h0A, 7'h0A};
                7'h1E: pair = {7'h41, 7'h61};
                7'h1F: pair = {7'h53, 7'h73};
                7'h20: pair = {7'h44, 7'h64};
                7'h21: pair = {7'h46, 7'h66};
                7'h22: pair = {7'h47, 7'h67};
                7'h23: pair = {7'h48, 7'h68};
                7'h24: pair = {7'h4A, 7'h6A};
                7'h25: pair = {7'h4B, 7'h6B};
                7'h26: pair = {7'h4C, 7'h6C};
                7'h27: pair = {7'h3A, 7'h3B};
                7'h28: pair = {7'h22, 7'h27};
                7'h29: pair = {7'h7E, 7'h60};
                7'h2B: pair = {7'h7C, 7'h5C};
                7'h2C: pair = {7'h5A, 7'h7A};
                7'h2D: pair = {7'h58, 7'h78};
                7'h2E: pair = {7'h43, 7'h63};
                7'h2F: pair = {7'h56, 7'h76};
                7'h30: pair = {7'h42, 7'h62};
                7'h31: pair = {7'h4E, 7'h6E};
                7'h32: pair = {7'h4D, 7'h6D};
                7'h33: pair = {7'h3C, 7'h2C};
                7'h34: pair = {7'h3E, 7'h2E};
                7'h35: pair = {7'h3F, 7'h2F};
                7'h37: pair = {7'h2A, 7'h2A};
                7'h39: pair = {7'h20, 7'h20};
                7'h4A: pair = {7'h2D, 7'h2D};
                7'h4E: pair = {7'h2B, 7'h2B};
                default: pair = {ASCII_NUL, ASCII_NUL};
            endcase
            km_entry = shifted ? pair[2*CH_W-1:CH_W] : pair[CH_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sc1a_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sc1a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scancode_set1_to_ascii_unit.sv =====
// Scan code set 1 to ASCII decoder, top level.
// Uses sc1a_pkg and sc1a_ram (key map storage).
//
// Usage:
// The s_ channel takes one keyboard byte per item in s_tdata; s_tuser marks
// a byte from the mouse, which is dropped. The m_ channel gives one ASCII
// character per item in m_tdata[6:0]; m_tlast marks the last character of
// the run caused by one input item.
// Shift, ctrl and caps-lock codes update internal flags and give no output;
// other release codes and unmapped keys give nothing either.
// Path: an accepted key is registered in the lookup stage and then in the
// output register, where it waits while that register is busy. A normal key
// gives one item; an up or down arrow gives ESC '[' 'A' or 'B', three items
// at the single output register, and the next key waits in the lookup stage.
// Reset: the key map RAM is loaded with all 256 entries from the package
// table, one entry per cycle; s_tready stays low until the load is done.
// Flags clear to zero. Stall: a held m_tready keeps the output item stable;
// one more input item waits in the lookup stage, after which s_tready drops.
`default_nettype none

module scancode_set1_to_ascii_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] scan_byte
    input  wire logic       s_tuser,   // [0] from_aux
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [6:0] char_code, [7] zero
    output logic            m_tlast
);
    import sc1a_pkg::*;

    // Table load after reset.
    logic             load_reg, load_next;
    logic [KM_AW-1:0] load_addr_reg, load_addr_next;

    // Modifier flags.
    logic shift_reg, shift_next;
    logic caps_reg, caps_next;
    logic ctrl_reg, ctrl_next;

    // Lookup stage: RAM data is valid here.
    logic      s1_valid_reg, s1_valid_next;
    kind_t     s1_kind_reg, s1_kind_next;
    logic      s1_caps_reg, s1_caps_next;
    logic      s1_ctrl_reg, s1_ctrl_next;

    // Output register and arrow run.
    logic            out_valid_reg, out_valid_next;
    logic [CH_W-1:0] out_char_reg, out_char_next;
    logic            out_last_reg, out_last_next;
    run_step_t       run_step_reg, run_step_next;
    logic [CH_W-1:0] run_letter_reg, run_letter_next;

    logic            s_acc, m_acc, s1_take, s1_adv, s1_emit, out_free, out_load;
    logic [CH_W-1:0] ram_rdata, ch_caps, ch_fin;

    sc1a_ram #(
        .WIDTH (CH_W),
        .DEPTH (KM_DEPTH)
    ) u_km_ram (
        .aclk  (aclk),
        .we    (load_reg),
        .waddr (load_addr_reg),
        .wdata (km_entry(load_addr_reg[KM_AW-1], load_addr_reg[KM_AW-2:0])),
        .re    (s1_take),
        .raddr ({shift_reg, s_tdata[6:0]}),
        .rdata (ram_rdata)
    );

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = out_valid_reg && m_tready;

    // Caps lock, then ctrl, applied to the looked-up character.
    always_comb begin
        ch_caps = ram_rdata;
        if (s1_caps_reg && (ram_rdata inside {[ASCII_LO_A:ASCII_LO_Z]})) begin
            ch_caps = ram_rdata & ~CASE_BIT;
        end
        ch_fin = ch_caps;
        if (s1_ctrl_reg && (ch_caps inside {[ASCII_LO_A:ASCII_LO_Z]})) begin
            ch_fin = ch_caps - (ASCII_LO_A - 7'd1);
        end else if (s1_ctrl_reg && (ch_caps inside {[ASCII_UP_A:ASCII_UP_Z]})) begin
            ch_fin = ch_caps - (ASCII_UP_A - 7'd1);
        end
    end

    assign out_free = !out_valid_reg || (m_acc && out_last_reg);
    assign s1_emit  = (s1_kind_reg != KIND_CHAR) || (ch_fin != ASCII_NUL);
    assign s1_adv   = s1_valid_reg && (out_free || !s1_emit);
    assign out_load = s1_valid_reg && s1_emit && out_free;
    assign s_tready = !load_reg && (!s1_valid_reg || s1_adv);

    // Input decode: modifiers change flags here, keys go on to the lookup.
    always_comb begin
        shift_next   = shift_reg;
        caps_next    = caps_reg;
        ctrl_next    = ctrl_reg;
        s1_take      = 1'b0;
        s1_kind_next = s1_kind_reg;
        if (s_acc && !s_tuser) begin
            case (s_tdata)
                SC_SHIFT_L_DN, SC_SHIFT_R_DN: shift_next = 1'b1;
                SC_SHIFT_L_UP, SC_SHIFT_R_UP: shift_next = 1'b0;
                SC_CTRL_DN:                   ctrl_next  = 1'b1;
                SC_CTRL_UP:                   ctrl_next  = 1'b0;
                SC_CAPS_DN:                   caps_next  = !caps_reg;
                SC_UP: begin
                    s1_take      = 1'b1;
                    s1_kind_next = KIND_UP;
                end
                SC_DOWN: begin
                    s1_take      = 1'b1;
                    s1_kind_next = KIND_DOWN;
                end
                default: begin
                    if (!s_tdata[7]) begin
                        s1_take      = 1'b1;
                        s1_kind_next = KIND_CHAR;
                    end
                end
            endcase
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_caps_next  = s1_caps_reg;
        s1_ctrl_next  = s1_ctrl_reg;
        if (s1_take) begin
            s1_valid_next = 1'b1;
            s1_caps_next  = caps_reg;
            s1_ctrl_next  = ctrl_reg;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        run_step_next   = run_step_reg;
        run_letter_next = run_letter_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            if (s1_kind_reg == KIND_CHAR) begin
                out_char_next = ch_fin;
                out_last_next = 1'b1;
            end else begin
                out_char_next   = ASCII_ESC;
                out_last_next   = 1'b0;
                run_step_next   = STEP_BRACKET;
                run_letter_next = (s1_kind_reg == KIND_UP) ? ASCII_UP_A : ASCII_UP_B;
            end
        end else if (m_acc) begin
            if (out_last_reg) begin
                out_valid_next = 1'b0;
            end else if (run_step_reg == STEP_BRACKET) begin
                out_char_next = ASCII_BRACKET;
                run_step_next = STEP_LETTER;
            end else begin
                out_char_next = run_letter_reg;
                out_last_next = 1'b1;
            end
        end
    end

    always_comb begin
        load_next      = load_reg;
        load_addr_next = load_addr_reg;
        if (load_reg) begin
            load_addr_next = load_addr_reg + 1'b1;
            if (&load_addr_reg) begin
                load_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg      <= 1'b1;
            load_addr_reg <= '0;
            shift_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            ctrl_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            load_reg      <= load_next;
            load_addr_reg <= load_addr_next;
            shift_reg     <= shift_next;
            caps_reg      <= caps_next;
            ctrl_reg      <= ctrl_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_kind_reg    <= s1_kind_next;
        s1_caps_reg    <= s1_caps_next;
        s1_ctrl_reg    <= s1_ctrl_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
        run_step_reg   <= run_step_next;
        run_letter_reg <= run_letter_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sc1a_chk.sv =====
// Port-level checker for the scan code set 1 to ASCII decoder, with its bind.
// Uses sc1a_pkg for the ASCII constants.
`default_nettype none

module sc1a_chk (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);
    import sc1a_pkg::*;

    // A stalled output item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // Only the first two characters of an arrow run are not last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |->
            m_tdata[6:0] == ASCII_ESC || m_tdata[6:0] == ASCII_BRACKET)
        else $error("non-last item outside an arrow run");

    // ESC in a run is followed at once by the bracket.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast && m_tdata[6:0] == ASCII_ESC |=>
            m_tvalid && !m_tlast && m_tdata[6:0] == ASCII_BRACKET)
        else $error("arrow run broken after ESC");

    // The bracket is followed at once by the closing arrow letter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast && m_tdata[6:0] == ASCII_BRACKET |=>
            m_tvalid && m_tlast &&
            (m_tdata[6:0] == ASCII_UP_A || m_tdata[6:0] == ASCII_UP_B))
        else $error("arrow run broken after bracket");

endmodule

bind scancode_set1_to_ascii_unit sc1a_chk u_sc1a_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for scancode_set1_to_ascii_unit: directed and random keyboard
// bytes go in over the s_ stream, and each ASCII item is checked against a scoreboard.
// Depends on sc1a_pkg and the RTL of the decoder; nothing else.
module testbench;
    import sc1a_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 67;

    // Key maps indexed by make code 0..79, entry 0 in the top byte; higher codes map to NUL.
    localparam bit [639:0] PLAIN_KEYS = {
        64'h001B313233343536, 64'h373839302D3D0809, 64'h7177657274797569,
        64'h6F705B5D0A006173, 64'h646667686A6B6C3B, 64'h2760005C7A786376,
        64'h626E6D2C2E2F002A, 64'h0020000000000000, 64'h0000000000000000,
        64'h00002D0000002B00};
    localparam bit [639:0] SHIFTED_KEYS = {
        64'h001B21402324255E, 64'h262A28295F2B0809, 64'h5157455254595549,
        64'h4F507B7D0A004153, 64'h444647484A4B4C3A, 64'h227E007C5A584356,
        64'h424E4D3C3E3F002A, 64'h0020000000000000, 64'h0000000000000000,
        64'h00002D0000002B00};

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } ascii_item_t;

    typedef struct packed {
        logic       aux;
        logic [7:0] scan;
    } key_item_t;

    int            cycle_count = 0;

    class key_scoreboard;
        bit          shift_held;
        bit          caps_lock;
        bit          ctrl_held;
        ascii_item_t pending_chars[$];
        int          mismatches;

        function void report_mismatch(string what);
            $display("mismatch at cycle %0d: %s", cycle_count, what);
            mismatches++;
        endfunction

        function logic [6:0] map_key(bit shifted, logic [6:0] idx);
            logic [7:0] entry;
            if (idx >= 7'd80)
                return ASCII_NUL;
            entry = shifted ? SHIFTED_KEYS[(79 - idx) * 8 +: 8] : PLAIN_KEYS[(79 - idx) * 8 +: 8];
            return entry[6:0];
        endfunction

        // Updates the modifier flags and queues the characters that one accepted byte gives.
        function void note_key(logic [7:0] scan, logic aux);
            logic [6:0] ch;
            if (aux)
                return;
            case (scan)
                SC_SHIFT_L_DN, SC_SHIFT_R_DN: shift_held = 1'b1;
                SC_SHIFT_L_UP, SC_SHIFT_R_UP: shift_held = 1'b0;
                SC_CTRL_DN: ctrl_held = 1'b1;
                SC_CTRL_UP: ctrl_held = 1'b0;
                SC_CAPS_DN: caps_lock = !caps_lock;
                SC_UP, SC_DOWN: begin
                    pending_chars.push_back('{ASCII_ESC, 1'b0});
                    pending_chars.push_back('{ASCII_BRACKET, 1'b0});
                    pending_chars.push_back('{(scan == SC_UP) ? ASCII_UP_A : ASCII_UP_B, 1'b1});
                end
                default: begin
                    if (!scan[7]) begin
                        ch = map_key(shift_held, scan[6:0]);
                        if (caps_lock && ch >= ASCII_LO_A && ch <= ASCII_LO_Z)
                            ch = ch & ~CASE_BIT;
                        if (ctrl_held && ch >= ASCII_LO_A && ch <= ASCII_LO_Z)
                            ch = ch - ASCII_LO_A + 7'd1;
                        else if (ctrl_held && ch >= ASCII_UP_A && ch <= ASCII_UP_Z)
                            ch = ch - ASCII_UP_A + 7'd1;
                        if (ch != ASCII_NUL)
                            pending_chars.push_back('{ch, 1'b1});
                    end
                end
            endcase
        endfunction

        function void check_char(logic [7:0] data, logic lst);
            ascii_item_t exp_item;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("item 0x%02h arrived with no character pending",
                                          data));
                return;
            end
            exp_item = pending_chars.pop_front();
            if (data[6:0] !== exp_item.code)
                report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                          data[6:0], exp_item.code));
            if (data[7] !== 1'b0)
                report_mismatch("padding bit 7 of m_tdata is not zero");
            if (lst !== exp_item.last)
                report_mismatch($sformatf("m_tlast %b, expected %b", lst, exp_item.last));
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int            tx_idle_pct = 0;
    int            rx_stall_pct = 0;
    bit            hold_request = 0;
    key_scoreboard sb = new;

    scancode_set1_to_ascii_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_key(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_char(m_tdata, m_tlast);
        end
    end

    // Output side: random stalls, with a long hold-off whenever one is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_key(key_item_t key);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key.scan;
        s_tuser  <= key.aux;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    function automatic key_item_t random_key();
        key_item_t  key;
        int unsigned pick;
        pick = $urandom_range(99);
        key.aux = 1'b0;
        if (pick < 6) begin
            key.aux  = 1'b1;
            key.scan = 8'($urandom);
        end else if (pick < 18) begin
            case ($urandom_range(6))
                0: key.scan = SC_SHIFT_L_DN;
                1: key.scan = SC_SHIFT_R_DN;
                2: key.scan = SC_SHIFT_L_UP;
                3: key.scan = SC_SHIFT_R_UP;
                4: key.scan = SC_CTRL_DN;
                5: key.scan = SC_CTRL_UP;
                default: key.scan = SC_CAPS_DN;
            endcase
        end else if (pick < 26) begin
            key.scan = $urandom_range(1) ? SC_UP : SC_DOWN;
        end else if (pick < 36) begin
            key.scan = {1'b1, 7'($urandom_range(127))};
        end else begin
            key.scan = {1'b0, 7'($urandom_range(127))};
        end
        return key;
    endfunction

    task automatic run_phase(int count, int tx_idle, int rx_stall);
        tx_idle_pct  = tx_idle;
        rx_stall_pct = rx_stall;
        for (int i = 0; i < count; i++)
            send_key(random_key());
    endtask

    initial begin
        key_item_t directed_keys[$];
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Plain keys, unmapped codes, ignored releases and mouse bytes, then every modifier,
        // caps lock with and without shift, ctrl letters and both arrows under modifiers.
        directed_keys = '{
            '{1'b0, 8'h1E}, '{1'b0, 8'h02}, '{1'b0, 8'h00}, '{1'b0, 8'h7F},
            '{1'b0, 8'hFF}, '{1'b1, 8'h1E}, '{1'b1, SC_SHIFT_L_DN}, '{1'b0, 8'h1E},
            '{1'b0, SC_SHIFT_L_DN}, '{1'b0, 8'h1E}, '{1'b0, 8'h02}, '{1'b0, SC_SHIFT_L_UP},
            '{1'b0, SC_SHIFT_R_DN}, '{1'b0, 8'h10}, '{1'b0, SC_SHIFT_R_UP}, '{1'b0, SC_CAPS_DN},
            '{1'b0, 8'h1E}, '{1'b0, 8'h02}, '{1'b0, SC_SHIFT_L_DN}, '{1'b0, 8'h1E},
            '{1'b0, SC_SHIFT_L_UP}, '{1'b0, 8'hBA}, '{1'b0, SC_CTRL_DN}, '{1'b0, 8'h1E},
            '{1'b0, 8'h2C}, '{1'b0, SC_UP}, '{1'b0, SC_DOWN}, '{1'b0, SC_CTRL_UP},
            '{1'b0, SC_CAPS_DN}, '{1'b0, 8'h80}};
        rx_stall_pct = 0;
        foreach (directed_keys[i])
            send_key(directed_keys[i]);

        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 67, 0);
        run_phase(PHASE_ITEMS, 0, 67);
        run_phase(PHASE_ITEMS, 25, 25);

        // Arrows alternating with random keys against a held output fill the pipeline and stall the input.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
            send_key((i % 2 == 0) ? key_item_t'({1'b0, SC_UP}) : random_key());
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

// ===== scancode_set1_to_ascii_unit.f =====
hw/rtl/sc1a_pkg.sv
hw/rtl/sc1a_ram.sv
hw/rtl/scancode_set1_to_ascii_unit.sv
hw/rtl/sc1a_chk.sv
tb/testbench.sv
